FILE: rtl/core/m3inv_pkg.sv
package m3inv_pkg;

    localparam int EW = 32;
    localparam int FB = 16;
    localparam int EPS_W = 31;
    localparam int EPS_RESET = 66;

    // product of two elements, cofactor, determinant widths
    localparam int PW = 2 * EW;
    localparam int CW = 2 * EW + 1;
    localparam int DW = 3 * EW + 2;
    // numerator = |cofactor| << 2*FB
    localparam int NW = CW + 2 * FB;
    // quotient bits kept: one spare above the element range catches overflow
    localparam int QW = EW + 1;

    typedef logic signed [EW-1:0] elem_t;

    typedef struct packed {
        elem_t [8:0] m;
    } mat_t;

    typedef struct packed {
        elem_t [8:0] m;
        logic        singular;
        logic        overflow;
    } res_t;

endpackage

FILE: rtl/core/m3inv_if.sv
interface m3inv_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/matrix3_inverse_core.sv
// 3x3 matrix inverse, signed Q16.16. One matrix may be accepted every cycle
// while out_res does not hold the pipeline back. Four stages form the cofactors
// and determinant, then come a two-entry queue, an entry stage for magnitudes
// and the overflow precheck, then 33 restoring divide stages (one quotient bit
// each) with saturation on the last stage's output. A matrix whose |det| is
// below det_epsilon (or zero) returns the identity with singular set.
// Quotients truncate toward zero and saturate with overflow set. Write
// det_epsilon only while the block is idle.
module matrix3_inverse_core (
    input  logic clk,
    input  logic rst_n,
    m3inv_if.sink   cfg,
    m3inv_if.sink   in_mat,
    m3inv_if.source out_res
);
    import m3inv_pkg::*;

    localparam int QDW = 9 * CW + DW + 1;

    logic [EPS_W-1:0]     eps_reg;
    logic                 f_valid, f_ready;
    logic signed [CW-1:0] f_adj [9];
    logic signed [DW-1:0] f_det;
    logic                 f_sing;
    logic [QDW-1:0]       f_pack, b_pack;
    logic                 b_valid, b_ready;
    logic signed [CW-1:0] b_adj [9];

    // det_epsilon register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_W'(EPS_RESET);
        else if (cfg.valid)
            eps_reg <= cfg.data[EPS_W-1:0];
    end

    m3inv_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_mat.valid), .in_ready(in_mat.ready), .in_mat(in_mat.data),
        .eps(eps_reg),
        .q_valid(f_valid), .q_ready(f_ready),
        .q_adj(f_adj), .q_det(f_det), .q_sing(f_sing)
    );

    always_comb
    begin
        f_pack = {f_sing, f_det, f_adj[8], f_adj[7], f_adj[6], f_adj[5], f_adj[4],
            f_adj[3], f_adj[2], f_adj[1], f_adj[0]};
        for (int k = 0; k < 9; k++)
            b_adj[k] = b_pack[k*CW +: CW];
    end

    m3inv_fifo #(.W(QDW)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_pack),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_pack)
    );

    m3inv_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(b_valid), .in_ready(b_ready),
        .in_adj(b_adj), .in_det(b_pack[9*CW +: DW]), .in_sing(b_pack[QDW-1]),
        .out_valid(out_res.valid), .out_ready(out_res.ready), .out_res(out_res.data)
    );
endmodule

FILE: rtl/core/m3inv_front.sv
// Front: cofactors and determinant, pipelined, classifies singular matrices.
module m3inv_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  m3inv_pkg::mat_t        in_mat,
    input  logic [m3inv_pkg::EPS_W-1:0] eps,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic signed [m3inv_pkg::CW-1:0] q_adj [9],
    output logic signed [m3inv_pkg::DW-1:0] q_det,
    output logic                   q_sing
);
    import m3inv_pkg::*;

    // stage 1: products
    logic                 v1_reg;
    logic signed [PW-1:0] p_reg [18];
    elem_t                a00_reg, a01_reg, a02_reg;
    // stage 2: cofactors
    logic                 v2_reg;
    logic signed [CW-1:0] adj_reg [9];
    elem_t                b00_reg, b01_reg, b02_reg;
    // stage 3: determinant partial products, cofactor split in low and high words
    logic                 v3_reg;
    logic signed [CW-1:0] tl_reg [3];
    logic signed [CW-1:0] th_reg [3];
    logic signed [CW-1:0] adj3_reg [9];
    // stage 4: determinant
    logic                 v4_reg;
    logic signed [DW-1:0] det_reg;
    logic signed [CW-1:0] adj4_reg [9];
    logic                 adv;
    logic [DW-1:0]        mdet;
    logic [DW-1:0]        lim;

    function automatic int ix(input int r, input int c);
        return r * 3 + c;
    endfunction

    // whole pipe moves when the tail is empty or taken
    assign adv = !v4_reg || q_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    p_reg[2*ix(r,c)] <= in_mat.m[ix((c+1)%3,(r+1)%3)]
                        * in_mat.m[ix((c+2)%3,(r+2)%3)];
                    p_reg[2*ix(r,c)+1] <= in_mat.m[ix((c+1)%3,(r+2)%3)]
                        * in_mat.m[ix((c+2)%3,(r+1)%3)];
                end
            end
            a00_reg <= in_mat.m[0];
            a01_reg <= in_mat.m[1];
            a02_reg <= in_mat.m[2];
            for (int k = 0; k < 9; k++)
                adj_reg[k] <= CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
            b00_reg <= a00_reg;
            b01_reg <= a01_reg;
            b02_reg <= a02_reg;
            // low word is unsigned, high word carries the sign
            tl_reg[0] <= b00_reg * $signed({1'b0, adj_reg[0][EW-1:0]});
            tl_reg[1] <= b01_reg * $signed({1'b0, adj_reg[3][EW-1:0]});
            tl_reg[2] <= b02_reg * $signed({1'b0, adj_reg[6][EW-1:0]});
            th_reg[0] <= b00_reg * $signed(adj_reg[0][CW-1:EW]);
            th_reg[1] <= b01_reg * $signed(adj_reg[3][CW-1:EW]);
            th_reg[2] <= b02_reg * $signed(adj_reg[6][CW-1:EW]);
            adj3_reg <= adj_reg;
            det_reg <= (DW'(th_reg[0]) <<< EW) + (DW'(th_reg[1]) <<< EW)
                + (DW'(th_reg[2]) <<< EW)
                + DW'(tl_reg[0]) + DW'(tl_reg[1]) + DW'(tl_reg[2]);
            adj4_reg <= adj3_reg;
        end
    end

    assign mdet = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    assign lim = DW'(eps) << (2 * FB);

    assign q_valid = v4_reg;
    assign q_adj = adj4_reg;
    assign q_det = det_reg;
    assign q_sing = (mdet == '0) || (mdet < lim);
endmodule

FILE: rtl/core/m3inv_fifo.sv
// Short queue between front and back.
module m3inv_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (wp_reg == rp_reg))
        else $error("empty queue pointers differ");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (wp_reg == rp_reg))
        else $error("full queue pointers differ");
`endif
endmodule

FILE: rtl/core/m3inv_back.sv
// Back: nine parallel restoring dividers, one quotient bit per stage.
module m3inv_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [m3inv_pkg::CW-1:0] in_adj [9],
    input  logic signed [m3inv_pkg::DW-1:0] in_det,
    input  logic                   in_sing,
    output logic                   out_valid,
    input  logic                   out_ready,
    output m3inv_pkg::res_t        out_res
);
    import m3inv_pkg::*;

    // Only quotient bits QW-1..0 matter; higher set bits mean overflow.
    // Numerator n = |adj| << 2FB; precheck: n >= d << QW gives overflow.
    localparam int S = QW;
    localparam int RW = DW + 1;

    logic          v_reg [S+1];
    logic          sg_reg [S+1];
    logic [DW-1:0] d_reg [S+1];
    logic [NW-1:0] n_reg [S+1][9];
    logic [RW-1:0] r_reg [S+1][9];
    logic [QW-1:0] q_reg [S+1][9];
    logic          ng_reg [S+1][9];
    logic          ov_reg [S+1][9];
    logic          adv;
    logic          ovf_any;
    res_t          res;
    logic [DW-1:0] md;

    assign adv = !v_reg[S] || out_ready;
    assign in_ready = adv;
    assign md = in_det[DW-1] ? DW'(-in_det) : DW'(in_det);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= S; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= S; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [CW-1:0] ma;
        logic [NW-1:0] nn;
        logic [RW-1:0] t;
        if (adv)
        begin
            // stage 0: magnitudes, signs, high-part overflow check
            sg_reg[0] <= in_sing;
            d_reg[0] <= md;
            for (int k = 0; k < 9; k++)
            begin
                ma = in_adj[k][CW-1] ? CW'(-in_adj[k]) : CW'(in_adj[k]);
                nn = NW'(ma) << (2 * FB);
                n_reg[0][k] <= nn;
                r_reg[0][k] <= '0;
                q_reg[0][k] <= '0;
                ng_reg[0][k] <= in_adj[k][CW-1] != in_det[DW-1];
                ov_reg[0][k] <= (nn >> QW) >= NW'(md);
            end
            // stages: start remainder at n >> QW (below d unless the precheck flagged overflow)
            for (int s = 1; s <= S; s++)
            begin
                sg_reg[s] <= sg_reg[s-1];
                d_reg[s] <= d_reg[s-1];
                for (int k = 0; k < 9; k++)
                begin
                    n_reg[s][k] <= n_reg[s-1][k];
                    ng_reg[s][k] <= ng_reg[s-1][k];
                    ov_reg[s][k] <= ov_reg[s-1][k];
                    if (s == 1)
                        t = {DW'(n_reg[s-1][k] >> QW), n_reg[s-1][k][S-s]};
                    else
                        t = {r_reg[s-1][k][RW-2:0], n_reg[s-1][k][S-s]};
                    if (t >= RW'(d_reg[s-1]))
                    begin
                        r_reg[s][k] <= t - RW'(d_reg[s-1]);
                        q_reg[s][k] <= {q_reg[s-1][k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[s][k] <= t;
                        q_reg[s][k] <= {q_reg[s-1][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // saturate and assemble
    always_comb
    begin
        logic [QW-1:0] q;
        logic          o;
        ovf_any = 1'b0;
        res = '0;
        for (int k = 0; k < 9; k++)
        begin
            q = q_reg[S][k];
            o = ov_reg[S][k];
            if (ng_reg[S][k] && q != '0)
            begin
                if (o || q > QW'({1'b1, {(EW-1){1'b0}}}))
                begin
                    o = 1'b1;
                    res.m[k] = {1'b1, {(EW-1){1'b0}}};
                end
                else
                    res.m[k] = EW'(-q);
            end
            else
            begin
                if (o || q[QW-1] || q[EW-1])
                begin
                    o = 1'b1;
                    res.m[k] = {1'b0, {(EW-1){1'b1}}};
                end
                else
                    res.m[k] = EW'(q);
            end
            ovf_any = ovf_any | o;
        end
        if (sg_reg[S])
        begin
            for (int k = 0; k < 9; k++)
                res.m[k] = (k % 4 == 0) ? EW'(1 << FB) : '0;
            ovf_any = 1'b0;
        end
        res.singular = sg_reg[S];
        res.overflow = ovf_any;
    end

    assign out_valid = v_reg[S];
    assign out_res = res;

`ifndef NO_ASSERTIONS
    a_sing_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.singular) |-> !out_res.overflow)
        else $error("singular result flagged overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    a_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.singular) |-> (out_res.m[0] == EW'(1 << FB)))
        else $error("singular result not identity");
`endif
endmodule

FILE: tb/m3inv_checker.sv
`timescale 1ns / 1ps

// Watches the channels of the inverse core, predicts every result and
// compares it with what comes out.
module m3inv_checker
    import m3inv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    m3inv_if     cfg_w,
    m3inv_if     mat_w,
    m3inv_if     res_w,
    output int   mismatches,
    output int   awaited
);

    typedef logic signed [191:0] wide_t;
    typedef logic [191:0] uwide_t;

    logic [EPS_W-1:0] eps_shadow;
    res_t             inv_queue[$];

    // saturate one quotient magnitude with its sign to an element
    function automatic elem_t clamp_elem(uwide_t q, logic neg, ref logic ovf);
        uwide_t bound;
        bound = neg ? (uwide_t'(1) << (EW - 1)) : ((uwide_t'(1) << (EW - 1)) - 1);
        if (q > bound)
        begin
            ovf = 1'b1;
            q = bound;
        end
        return neg ? elem_t'(-q) : elem_t'(q);
    endfunction

    // exact adjugate over determinant, truncated toward zero
    function automatic res_t inverse_of(mat_t a, logic [EPS_W-1:0] eps);
        wide_t  e[3][3];
        wide_t  cof[3][3];
        wide_t  det;
        uwide_t mdet, lim, num, q, mag;
        logic   neg, ovf;
        res_t   r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = {{(192 - EW){a.m[i * 3 + j][EW - 1]}}, a.m[i * 3 + j]};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = e[(j + 1) % 3][(i + 1) % 3] * e[(j + 2) % 3][(i + 2) % 3]
                          - e[(j + 1) % 3][(i + 2) % 3] * e[(j + 2) % 3][(i + 1) % 3];
        det = e[0][0] * cof[0][0] + e[0][1] * cof[1][0] + e[0][2] * cof[2][0];
        mdet = (det < 0) ? uwide_t'(-det) : uwide_t'(det);
        lim = uwide_t'(eps) << (2 * FB);
        ovf = 1'b0;
        r = '0;
        if (mdet == 0 || mdet < lim)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r.m[i * 3 + j] = (i == j) ? elem_t'(1 << FB) : elem_t'(0);
            r.singular = 1'b1;
            r.overflow = 1'b0;
            return r;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                neg = (cof[i][j] < 0) != (det < 0);
                mag = (cof[i][j] < 0) ? uwide_t'(-cof[i][j]) : uwide_t'(cof[i][j]);
                num = mag << (2 * FB);
                q = num / mdet;
                if (q == 0)
                    neg = 1'b0;
                r.m[i * 3 + j] = clamp_elem(q, neg, ovf);
            end
        r.singular = 1'b0;
        r.overflow = ovf;
        return r;
    endfunction

    assign awaited = inv_queue.size();

    // track register, predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        res_t want, got;
        if (!rst_n)
        begin
            eps_shadow <= EPS_W'(EPS_RESET);
            mismatches <= 0;
        end
        else
        begin
            if (cfg_w.valid && cfg_w.ready)
                eps_shadow <= cfg_w.data;
            if (mat_w.valid && mat_w.ready)
                inv_queue.push_back(inverse_of(mat_w.data, eps_shadow));
            if (res_w.valid && res_w.ready)
            begin
                got = res_w.data;
                if (inv_queue.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = inv_queue.pop_front();
                    if (got !== want)
                        mismatches <= mismatches + 1;
                    for (int k = 0; k < 9; k++)
                        if (got.m[k] !== want.m[k])
                            $error("out_c%0d_r%0d expected %0d got %0d",
                                   k % 3, k / 3, want.m[k], got.m[k]);
                    if (got.singular !== want.singular)
                        $error("singular expected %0d got %0d",
                               want.singular, got.singular);
                    if (got.overflow !== want.overflow)
                        $error("overflow expected %0d got %0d",
                               want.overflow, got.overflow);
                end
            end
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import m3inv_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN = 60;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   awaited;
    int   cycles;
    bit   no_idle;
    bit   hold_req;

    m3inv_if #(.T(logic [EPS_W-1:0])) cfg_if ();
    m3inv_if #(.T(mat_t))             mat_if ();
    m3inv_if #(.T(res_t))             res_if ();

    matrix3_inverse_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .in_mat  (mat_if),
        .out_res (res_if)
    );

    m3inv_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_w      (cfg_if),
        .mat_w      (mat_if),
        .res_w      (res_if),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (hold_req)
            begin
                stall = 400;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
        end
    end

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 7))
            0, 1: return elem_t'($urandom);
            2: case ($urandom_range(0, 5))
                   0: return 32'sh7fffffff;
                   1: return 32'sh80000000;
                   2: return 32'sh0;
                   3: return 32'sh1;
                   4: return -32'sh1;
                   default: return 32'sh10000;
               endcase
            3: return elem_t'($signed($urandom_range(0, 31)) - 16);
            default: return elem_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
        endcase
    endfunction

    function automatic mat_t rand_mat();
        mat_t x;
        int   src, dst;
        for (int k = 0; k < 9; k++)
            x.m[k] = rand_elem();
        // copy one row over another for an exactly singular matrix
        if ($urandom_range(0, 7) == 0)
        begin
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            for (int j = 0; j < 3; j++)
                x.m[dst * 3 + j] = x.m[src * 3 + j];
        end
        return x;
    endfunction

    function automatic mat_t diag_mat(elem_t d0, elem_t d1, elem_t d2);
        mat_t x;
        x = '0;
        x.m[0] = d0;
        x.m[4] = d1;
        x.m[8] = d2;
        return x;
    endfunction

    function automatic mat_t fill_mat(elem_t v);
        mat_t x;
        for (int k = 0; k < 9; k++)
            x.m[k] = v;
        return x;
    endfunction

    task automatic send_mat(mat_t x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            mat_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mat_if.valid <= 1'b1;
        mat_if.data  <= x;
        @(posedge clk);
        while (!mat_if.ready)
            @(posedge clk);
    endtask

    // wait out every outstanding result, then write the threshold
    task automatic set_epsilon(logic [EPS_W-1:0] v);
        mat_if.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_mat(rand_mat());
    endtask

    initial
    begin
        mat_t x;
        rst_n = 1'b0;
        no_idle = 0;
        hold_req = 0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        mat_if.valid = 1'b0;
        mat_if.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed matrices at the reset threshold
        send_mat(diag_mat(32'sh10000, 32'sh10000, 32'sh10000));
        send_mat(fill_mat(32'sh0));
        send_mat(fill_mat(32'sh7fffffff));
        send_mat(fill_mat(32'sh80000000));
        send_mat(diag_mat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_mat(diag_mat(32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_mat(diag_mat(32'sh80000000, 32'sh7fffffff, -32'sh1));
        send_mat(diag_mat(32'sh1, 32'sh1, 32'sh1));
        send_mat(diag_mat(32'sh100, 32'sh100, 32'sh100));
        send_mat(diag_mat(32'sh20000, -32'sh30000, 32'sh8000));
        send_mat(diag_mat(-32'sh10000, 32'sh10000, -32'sh10000));
        x = diag_mat(32'sh10000, 32'sh10000, 32'sh10000);
        x.m[1] = 32'sh7fffffff;
        x.m[5] = 32'sh80000000;
        send_mat(x);
        x = '0;
        x.m[1] = 32'sh10000;
        x.m[5] = 32'sh10000;
        x.m[6] = 32'sh10000;
        send_mat(x);
        x = fill_mat(32'sh10000);
        x.m[0] = 32'sh10001;
        send_mat(x);
        send_mat(diag_mat(32'sh7fff, 32'sh8000, 32'sh8000));
        send_random(240);

        // zero threshold: only an exact zero determinant is singular
        set_epsilon('0);
        send_mat(diag_mat(32'sh1, 32'sh1, 32'sh1));
        send_mat(diag_mat(-32'sh1, 32'sh1, 32'sh1));
        send_mat(fill_mat(32'sh0));
        send_random(250);

        // widest threshold: nearly everything singular
        set_epsilon({EPS_W{1'b1}});
        send_random(100);

        // random threshold, back to back with one long result hold-off
        set_epsilon(EPS_W'($urandom));
        no_idle = 1;
        hold_req = 1;
        send_random(200);
        no_idle = 0;

        set_epsilon(EPS_W'($urandom_range(1, 5000)));
        send_random(200);

        mat_if.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: matrix3_inverse_core.f
rtl/core/m3inv_pkg.sv
rtl/core/m3inv_if.sv
rtl/core/m3inv_front.sv
rtl/core/m3inv_fifo.sv
rtl/core/m3inv_back.sv
rtl/core/matrix3_inverse_core.sv
tb/m3inv_checker.sv
tb/tb.sv
